>>> design/rcs_pkg.sv
package rcs_pkg;

  localparam int WORDS_PER_REC = 12;
  localparam logic [3:0] LAST_WORD = 4'd11;

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_FINISH = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PARTIAL = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_BADRD   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDOUT,
    S_NEXT,
    S_TEST,
    S_CMP
  } state_t;

  typedef struct packed {
    logic init;
    logic wr;
    logic take_left;
  } cell_ctl_t;

  // Byte-reversed key slice of one record word: lower byte index ends up more
  // significant, bytes outside the key are zeroed.
  function automatic logic [63:0] key_slice(input logic [63:0] word, input logic [3:0] widx);
    logic [63:0] rev;
    rev = '0;
    for (int b = 0; b < 8; b++) begin
      rev[8*(7-b) +: 8] = word[8*b +: 8];
    end
    if (widx == 4'd0) begin
      rev[63:32] = '0;
    end else if (widx == LAST_WORD) begin
      rev[15:0] = '0;
    end
    return rev;
  endfunction

endpackage

>>> design/record_chunk_sorter.sv
// Finish: insertion sort of the order cells; each record i is compared with its
//   left neighbors word by word (up to 12 words) and moves left while it is less.
// Throughput: one item at a time; a new item is taken only in the idle state and
//   while the output is not held by out_stall.
// Reset (rst_n low, synchronous): chunk empty, not sorted, chunk size 64.
// Record storage and order cells are not cleared.
module record_chunk_sorter #(
  parameter int MAX_RECORDS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [63:0] in_data_word,
  input  logic [5:0]  in_rank,
  input  logic [3:0]  in_word_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_data_out,
  output logic [1:0]  out_status,
  output logic [6:0]  out_records_held
);
  import rcs_pkg::*;

  localparam int IW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam int DEPTH = MAX_RECORDS * WORDS_PER_REC;
  localparam int AW = $clog2(DEPTH);

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [3:0]    wp_r, wp_nxt, w_r, w_nxt;
  logic          sorted_r, sorted_nxt, ok_r, ok_nxt;
  logic [6:0]    cfg_r;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [31:0]   ida_r, ida_nxt, idb_r, idb_nxt;
  logic [1:0]    st_r, st_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [63:0]   out_data_r, out_data_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [6:0]    out_held_r, out_held_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [63:0]   rd_a, rd_b;
  logic          lt, gt;

  cell_ctl_t     ctl;
  logic [IW-1:0] pos, wval, sel_idx, sel_val;
  logic [IW-1:0] vals [MAX_RECORDS];

  logic          acc, produce;
  logic [63:0]   p_data;
  logic [1:0]    p_status;
  logic [31:0]   lim, ec32;
  logic [CW-1:0] ec;
  logic [3:0]    ewp;
  logic          bad, less;

  assign acc = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign sel_val = vals[sel_idx];

  always_comb begin
    if (cfg_r == 7'd0) begin
      lim = 32'd1;
    end else if (32'(cfg_r) > 32'(MAX_RECORDS)) begin
      lim = 32'(MAX_RECORDS);
    end else begin
      lim = 32'(cfg_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    wp_nxt = wp_r;
    sorted_nxt = sorted_r;
    i_nxt = i_r;
    j_nxt = j_r;
    cur_nxt = cur_r;
    w_nxt = w_r;
    ida_nxt = ida_r;
    idb_nxt = idb_r;
    st_nxt = st_r;
    ok_nxt = ok_r;
    we = 1'b0;
    waddr = '0;
    raddr_a = '0;
    raddr_b = '0;
    ctl = '0;
    pos = '0;
    wval = cur_r;
    sel_idx = '0;
    produce = 1'b0;
    p_data = '0;
    p_status = ST_OK;
    ec = sorted_r ? '0 : count_r;
    ewp = sorted_r ? 4'd0 : wp_r;
    ec32 = 32'(ec);
    bad = 1'b0;
    less = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_mode)
            MODE_LOAD: begin
              produce = 1'b1;
              sorted_nxt = 1'b0;
              count_nxt = ec;
              wp_nxt = ewp;
              if (ec32 >= lim) begin
                p_status = ST_FULL;
              end else begin
                we = 1'b1;
                waddr = AW'(ec32 * 32'd12 + 32'(ewp));
                if (ewp == LAST_WORD) begin
                  wp_nxt = 4'd0;
                  count_nxt = ec + CW'(1);
                end else begin
                  wp_nxt = ewp + 4'd1;
                end
              end
            end
            MODE_FINISH: begin
              st_nxt = (wp_r != 4'd0) ? ST_PARTIAL : ST_OK;
              wp_nxt = 4'd0;
              ctl.init = 1'b1;
              i_nxt = CW'(1);
              sorted_nxt = 1'b1;
              state_nxt = S_NEXT;
            end
            MODE_READ: begin
              bad = !sorted_r || (32'(in_rank) >= 32'(count_r)) ||
                    (in_word_index > LAST_WORD);
              sel_idx = IW'(in_rank);
              raddr_a = AW'(32'(sel_val) * 32'd12 + 32'(in_word_index));
              ok_nxt = !bad;
              st_nxt = bad ? ST_BADRD : ST_OK;
              state_nxt = S_RDOUT;
            end
            default: begin
              produce = 1'b1;
            end
          endcase
        end
      end
      S_RDOUT: begin
        produce = 1'b1;
        p_data = ok_r ? rd_a : 64'd0;
        p_status = st_r;
        state_nxt = S_IDLE;
      end
      S_NEXT: begin
        if (32'(i_r) >= 32'(count_r)) begin
          produce = 1'b1;
          p_status = st_r;
          state_nxt = S_IDLE;
        end else begin
          j_nxt = i_r;
          cur_nxt = IW'(i_r);
          w_nxt = 4'd0;
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (j_r == '0) begin
          ctl.wr = 1'b1;
          pos = '0;
          i_nxt = i_r + CW'(1);
          state_nxt = S_NEXT;
        end else begin
          sel_idx = IW'(j_r - CW'(1));
          raddr_a = AW'(32'(cur_r) * 32'd12);
          raddr_b = AW'(32'(sel_val) * 32'd12);
          w_nxt = 4'd0;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        sel_idx = IW'(j_r - CW'(1));
        if (w_r == 4'd0) begin
          ida_nxt = rd_a[31:0];
          idb_nxt = rd_b[31:0];
        end
        if (!lt && !gt && w_r != LAST_WORD) begin
          w_nxt = w_r + 4'd1;
          raddr_a = AW'(32'(cur_r) * 32'd12 + 32'(w_nxt));
          raddr_b = AW'(32'(sel_val) * 32'd12 + 32'(w_nxt));
        end else begin
          if (lt || gt) begin
            less = lt;
          end else begin
            less = $signed(ida_r) < $signed(idb_r);
          end
          ctl.wr = 1'b1;
          pos = IW'(j_r);
          if (less) begin
            ctl.take_left = 1'b1;
            j_nxt = j_r - CW'(1);
            state_nxt = S_TEST;
          end else begin
            i_nxt = i_r + CW'(1);
            state_nxt = S_NEXT;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt = out_data_r;
    out_status_nxt = out_status_r;
    out_held_nxt = out_held_r;
    if (produce) begin
      out_valid_nxt = 1'b1;
      out_data_nxt = p_data;
      out_status_nxt = p_status;
      out_held_nxt = 7'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      wp_r <= 4'd0;
      sorted_r <= 1'b0;
      cfg_r <= 7'd64;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      wp_r <= wp_nxt;
      sorted_r <= sorted_nxt;
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    cur_r <= cur_nxt;
    w_r <= w_nxt;
    ida_r <= ida_nxt;
    idb_r <= idb_nxt;
    st_r <= st_nxt;
    ok_r <= ok_nxt;
    out_data_r <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_held_r <= out_held_nxt;
  end

  // Two copies of the record store give two read ports.
  rcs_ram #(.W(64), .D(DEPTH)) u_ram_a (
    .clk(clk), .we(we), .waddr(waddr), .wdata(in_data_word),
    .raddr(raddr_a), .rdata(rd_a)
  );

  rcs_ram #(.W(64), .D(DEPTH)) u_ram_b (
    .clk(clk), .we(we), .waddr(waddr), .wdata(in_data_word),
    .raddr(raddr_b), .rdata(rd_b)
  );

  rcs_key_cmp u_cmp (
    .word_a(rd_a), .word_b(rd_b), .widx(w_r), .lt(lt), .gt(gt)
  );

  for (genvar k = 0; k < MAX_RECORDS; k++) begin : g_cell
    logic [IW-1:0] left;
    if (k == 0) begin : g_first
      assign left = '0;
    end else begin : g_rest
      assign left = vals[k-1];
    end
    rcs_cell #(.IW(IW), .IDX(k)) u_cell (
      .clk(clk), .ctl(ctl), .pos(pos), .wval(wval), .left(left), .val(vals[k])
    );
  end

  assign out_valid = out_valid_r;
  assign out_data_out = out_data_r;
  assign out_status = out_status_r;
  assign out_records_held = out_held_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(MAX_RECORDS))
    else $error("record count above capacity");

  a_j_le_i: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TEST || state_r == S_CMP) |-> (j_r <= i_r && i_r < count_r))
    else $error("insertion walk out of range");

  a_word_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (w_r <= LAST_WORD && j_r != '0))
    else $error("compare word index out of range");

  a_sort_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NEXT && 32'(i_r) < 32'(count_r)) |=> (state_r == S_TEST))
    else $error("insertion step lost");

endmodule

>>> design/rcs_ram.sv
module rcs_ram #(
  parameter int W = 64,
  parameter int D = 768
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/rcs_key_cmp.sv
module rcs_key_cmp (
  input  logic [63:0] word_a,
  input  logic [63:0] word_b,
  input  logic [3:0]  widx,
  output logic        lt,
  output logic        gt
);
  import rcs_pkg::*;

  logic [63:0] ka, kb;

  always_comb begin
    ka = key_slice(word_a, widx);
    kb = key_slice(word_b, widx);
    lt = ka < kb;
    gt = ka > kb;
  end

endmodule

>>> design/rcs_cell.sv
// One slot of the sorted order; on a shift it takes its left neighbor.
module rcs_cell #(
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  logic               clk,
  input  rcs_pkg::cell_ctl_t ctl,
  input  logic [IW-1:0]      pos,
  input  logic [IW-1:0]      wval,
  input  logic [IW-1:0]      left,
  output logic [IW-1:0]      val
);
  import rcs_pkg::*;

  logic [IW-1:0] val_r, val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctl.init) begin
      val_nxt = IW'(IDX);
    end else if (ctl.wr && pos == IW'(IDX)) begin
      val_nxt = ctl.take_left ? left : wval;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule
